FILE: sv/assert_macros.svh
// -----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on clk and disabled while
// rst_n is low.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset
`define SFCC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Check that a condition never holds outside reset
`define SFCC_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

FILE: sv/sfcc_pkg.sv
// -----------------------------------------------------------------------------
// sfcc_pkg
// Types, widths, register codes, reset values and the CRC-8 column table
// shared by the sensor frame check and scale block.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sfcc_pkg;

    localparam int BYTE_W      = 8;
    localparam int READING_W   = 16;
    localparam int GAIN_W      = 20;
    localparam int OFFSET_W    = 21;
    localparam int SCALED_W    = 22;
    localparam int CFG_DATA_W  = 21;
    localparam int CFG_INDEX_W = 2;
    localparam int SCALE_SHIFT = 16;
    localparam int PRODUCT_W   = READING_W + GAIN_W;
    localparam int TERM_W      = PRODUCT_W - SCALE_SHIFT;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_TEMP_GAIN   = 2'd0,
        REG_TEMP_OFFSET = 2'd1,
        REG_HUM_GAIN    = 2'd2,
        REG_HUM_OFFSET  = 2'd3
    } cfg_reg_t;

    // Reading kind codes
    typedef enum logic {
        KIND_TEMPERATURE = 1'b0,
        KIND_HUMIDITY    = 1'b1
    } kind_t;

    // Result status codes
    typedef enum logic {
        STATUS_OK      = 1'b0,
        STATUS_CRC_ERR = 1'b1
    } status_t;

    // Reset values of the coefficient registers
    localparam logic [GAIN_W-1:0]          TEMP_GAIN_RST   = 20'd44984;
    localparam logic signed [OFFSET_W-1:0] TEMP_OFFSET_RST = -21'sd11994;
    localparam logic [GAIN_W-1:0]          HUM_GAIN_RST    = 20'd32000;
    localparam logic signed [OFFSET_W-1:0] HUM_OFFSET_RST  = -21'sd1536;

    // Gain and offset for one reading kind
    typedef struct packed {
        logic [GAIN_W-1:0]          gain;
        logic signed [OFFSET_W-1:0] offset;
    } coef_t;

    // CRC-8 (poly 0x31, init 0, MSB first) is linear in the reading: entry i
    // is the CRC of a reading with only bit i set.
    localparam logic [BYTE_W-1:0] CRC_COLUMN [READING_W] = '{
        8'h31, 8'h62, 8'hC4, 8'hB9, 8'h43, 8'h86, 8'h3D, 8'h7A,
        8'hF4, 8'hD9, 8'h83, 8'h37, 8'h6E, 8'hDC, 8'h89, 8'h23
    };

endpackage

FILE: sv/sensor_frame_crc_check_and_scale.sv
// -----------------------------------------------------------------------------
// sensor_frame_crc_check_and_scale
// Checks a three-byte sensor reply against its CRC-8 and scales the reading
// with per-kind gain and offset.
//
// Usage:
//   Input channel (in_valid/in_ready) carries high_byte, low_byte,
//   check_byte and reading_kind. Output channel (out_valid/out_ready)
//   carries status, raw_reading and scaled_value, one result per reply.
//   A reply is captured into the input register on its transfer; CRC and
//   scaling run between the input register and the result register, so a
//   result is offered once its reply has moved from the input register into
//   the result register; that move waits while an earlier result is stalled.
//   Throughput is one reply per cycle while out_ready stays high; the
//   multiply-add is combinational between the two registers.
//   When the receiver stalls, the result register holds and one more reply
//   can still be taken into the input register; in_ready drops only when
//   both registers are full and out_ready is low.
//   Reset empties both registers and loads the default gains and offsets.
//   Write coefficients through cfg_we/cfg_index/cfg_data while idle.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sensor_frame_crc_check_and_scale (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // Configuration write port
    input  logic                                 cfg_we,
    input  logic [sfcc_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [sfcc_pkg::CFG_DATA_W-1:0]      cfg_data,
    // Input channel
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [sfcc_pkg::BYTE_W-1:0]          high_byte,
    input  logic [sfcc_pkg::BYTE_W-1:0]          low_byte,
    input  logic [sfcc_pkg::BYTE_W-1:0]          check_byte,
    input  logic                                 reading_kind,
    // Output channel
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic                                 status,
    output logic [sfcc_pkg::READING_W-1:0]       raw_reading,
    output logic signed [sfcc_pkg::SCALED_W-1:0] scaled_value
);
    import sfcc_pkg::*;

    logic                       s1_valid_reg;
    logic [READING_W-1:0]       s1_reading_reg;
    logic [BYTE_W-1:0]          s1_check_reg;
    logic                       s1_kind_reg;

    logic                       out_valid_reg;
    logic                       status_reg;
    logic [READING_W-1:0]       raw_reg;
    logic signed [SCALED_W-1:0] scaled_reg;

    logic                       advance;
    logic                       in_xfer;
    logic                       crc_ok;
    coef_t                      coef;
    logic signed [SCALED_W-1:0] scaled_next;
    logic                       status_next;

    // Move a result forward when the result register is empty or drains
    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = !s1_valid_reg || advance;
    assign in_xfer  = in_valid && in_ready;

    // Hold the input register valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    // Capture the reply on an input transfer
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_reading_reg <= {high_byte, low_byte};
            s1_check_reg   <= check_byte;
            s1_kind_reg    <= reading_kind;
        end
    end

    sfcc_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .kind      (s1_kind_reg),
        .coef      (coef)
    );

    sfcc_crc8 u_crc8 (
        .reading    (s1_reading_reg),
        .check_byte (s1_check_reg),
        .crc_ok     (crc_ok)
    );

    sfcc_scale u_scale (
        .reading (s1_reading_reg),
        .coef    (coef),
        .crc_ok  (crc_ok),
        .scaled  (scaled_next)
    );

    assign status_next = crc_ok ? STATUS_OK : STATUS_CRC_ERR;

    // Hold the result register valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    // Load the result when it advances
    always_ff @(posedge clk)
    begin
        if (advance && s1_valid_reg)
        begin
            status_reg <= status_next;
            raw_reg    <= s1_reading_reg;
            scaled_reg <= scaled_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign raw_reading  = raw_reg;
    assign scaled_value = scaled_reg;

    // A failed check always carries a zero value
    `SFCC_ASSERT(a_err_zero, out_valid_reg && status_reg |-> scaled_reg == '0,
        "CRC error result with nonzero scaled value")

    // A stalled input register keeps its reply
    `SFCC_ASSERT(a_s1_hold, s1_valid_reg && !advance |=>
        s1_valid_reg && $stable(s1_reading_reg) && $stable(s1_check_reg)
        && $stable(s1_kind_reg), "input register lost its reply during a stall")

    // A transfer into a full, stalled pipeline is impossible
    `SFCC_NEVER(a_no_overrun, in_xfer && s1_valid_reg && !advance,
        "input transfer while both registers full")

    // A reply that advances becomes a valid result
    `SFCC_ASSERT(a_advance_lands, advance && s1_valid_reg |=> out_valid_reg,
        "advanced reply did not reach the result register")

endmodule

FILE: sv/sfcc_cfg_regs.sv
// -----------------------------------------------------------------------------
// sfcc_cfg_regs
// Gain and offset registers for both reading kinds, with the per-kind
// coefficient select.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sfcc_cfg_regs (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [sfcc_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [sfcc_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                               kind,
    output sfcc_pkg::coef_t                    coef
);
    import sfcc_pkg::*;

    logic [GAIN_W-1:0]          temp_gain_reg;
    logic signed [OFFSET_W-1:0] temp_offset_reg;
    logic [GAIN_W-1:0]          hum_gain_reg;
    logic signed [OFFSET_W-1:0] hum_offset_reg;

    // Write the addressed register, keeping the low bits of its field width
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_gain_reg   <= TEMP_GAIN_RST;
            temp_offset_reg <= TEMP_OFFSET_RST;
            hum_gain_reg    <= HUM_GAIN_RST;
            hum_offset_reg  <= HUM_OFFSET_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_TEMP_GAIN:   temp_gain_reg   <= cfg_data[GAIN_W-1:0];
                REG_TEMP_OFFSET: temp_offset_reg <= $signed(cfg_data[OFFSET_W-1:0]);
                REG_HUM_GAIN:    hum_gain_reg    <= cfg_data[GAIN_W-1:0];
                REG_HUM_OFFSET:  hum_offset_reg  <= $signed(cfg_data[OFFSET_W-1:0]);
                default:         ;
            endcase
        end
    end

    // Select the coefficients of the requested kind
    always_comb
    begin
        case (kind_t'(kind))
            KIND_HUMIDITY:
            begin
                coef.gain   = hum_gain_reg;
                coef.offset = hum_offset_reg;
            end
            default:
            begin
                coef.gain   = temp_gain_reg;
                coef.offset = temp_offset_reg;
            end
        endcase
    end

endmodule

FILE: sv/sfcc_crc8.sv
// -----------------------------------------------------------------------------
// sfcc_crc8
// CRC-8 of the 16-bit reading (poly x^8+x^5+x^4+1, init 0, no reflection)
// compared against the received check byte.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sfcc_crc8 (
    input  logic [sfcc_pkg::READING_W-1:0] reading,
    input  logic [sfcc_pkg::BYTE_W-1:0]    check_byte,
    output logic                           crc_ok
);
    import sfcc_pkg::*;

    logic [BYTE_W-1:0] crc;

    // Fold in the column of every set reading bit
    always_comb
    begin
        crc = '0;
        for (int i = 0; i < READING_W; i++)
        begin
            if (reading[i])
            begin
                crc = crc ^ CRC_COLUMN[i];
            end
        end
    end

    assign crc_ok = (crc == check_byte);

endmodule

FILE: sv/sfcc_scale.sv
// -----------------------------------------------------------------------------
// sfcc_scale
// Linear scaling of the reading: (reading * gain) >> 16 plus offset, forced
// to zero when the check byte does not match.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sfcc_scale (
    input  logic [sfcc_pkg::READING_W-1:0]       reading,
    input  sfcc_pkg::coef_t                      coef,
    input  logic                                 crc_ok,
    output logic signed [sfcc_pkg::SCALED_W-1:0] scaled
);
    import sfcc_pkg::*;

    logic [PRODUCT_W-1:0]       product;
    logic [TERM_W-1:0]          term;
    logic signed [SCALED_W-1:0] sum;

    // Multiply, drop the fraction, add the sign-extended offset
    assign product = PRODUCT_W'(reading) * PRODUCT_W'(coef.gain);
    assign term    = product[PRODUCT_W-1:SCALE_SHIFT];
    assign sum     = $signed({{(SCALED_W-TERM_W){1'b0}}, term})
                   + $signed({{(SCALED_W-OFFSET_W){coef.offset[OFFSET_W-1]}}, coef.offset});

    // Zero the value on a check failure
    assign scaled = crc_ok ? sum : '0;

endmodule
